FILE: hw/rtl/svl_pkg.sv
`default_nettype none
package svl_pkg;

  // Default table depth
  localparam int unsigned MAX_POINTS = 64;
  // Query coordinates saturate to GRID_SIZE-1
  localparam int unsigned GRID_SIZE  = 256;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned IDX_W   = 6;
  // 3 * 255^2 fits in 18 bits
  localparam int unsigned DIST_W  = 18;

  // Request command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [VALUE_W-1:0] value;
  } seed_entry_t;

  // Clamp a query coordinate to the grid
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] c);
    logic [16:0] lim;
    lim = 17'(GRID_SIZE - 1);
    if ({9'd0, c} > lim) begin
      return lim[COORD_W-1:0];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/svl_if.sv
`default_nettype none
// Request channel
interface svl_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [svl_pkg::COORD_W-1:0]   coord_x;
  logic [svl_pkg::COORD_W-1:0]   coord_y;
  logic [svl_pkg::COORD_W-1:0]   coord_z;
  logic [svl_pkg::VALUE_W-1:0]   seed_value;

  modport source (output valid, command, coord_x, coord_y, coord_z, seed_value,
                  input ready);
  modport sink   (input valid, command, coord_x, coord_y, coord_z, seed_value,
                  output ready);
endinterface

// Result channel
interface svl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [svl_pkg::VALUE_W-1:0]   nearest_value;
  logic [svl_pkg::IDX_W-1:0]     nearest_index;
  logic                          table_empty;

  modport source (output valid, nearest_value, nearest_index, table_empty,
                  input ready);
  modport sink   (input valid, nearest_value, nearest_index, table_empty,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/svl_seed_mem.sv
`default_nettype none
// Seed table: one write port, one read port, registered read data
module svl_seed_mem #(
  parameter int unsigned DEPTH = svl_pkg::MAX_POINTS,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire svl_pkg::seed_entry_t wdata,
  input  wire logic [AW-1:0]        raddr,
  output svl_pkg::seed_entry_t      rdata
);

  svl_pkg::seed_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/svl_dist.sv
`default_nettype none
// Squared distance stage: one seed per cycle, result registered
module svl_dist #(
  parameter int unsigned AW = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire svl_pkg::seed_entry_t          seed,
  input  wire logic [AW-1:0]                 in_idx,
  input  wire logic [svl_pkg::COORD_W-1:0]   qx,
  input  wire logic [svl_pkg::COORD_W-1:0]   qy,
  input  wire logic [svl_pkg::COORD_W-1:0]   qz,
  output logic                               out_valid,
  output logic [svl_pkg::DIST_W-1:0]         out_dist,
  output logic [svl_pkg::VALUE_W-1:0]        out_value,
  output logic [AW-1:0]                      out_idx
);

  logic [svl_pkg::COORD_W-1:0]   dx, dy, dz;
  logic [2*svl_pkg::COORD_W-1:0] sx, sy, sz;
  logic [svl_pkg::DIST_W-1:0]    dsum;

  // Absolute differences and squares
  always_comb begin
    dx   = (seed.x > qx) ? seed.x - qx : qx - seed.x;
    dy   = (seed.y > qy) ? seed.y - qy : qy - seed.y;
    dz   = (seed.z > qz) ? seed.z - qz : qz - seed.z;
    sx   = dx * dx;
    sy   = dy * dy;
    sz   = dz * dz;
    dsum = svl_pkg::DIST_W'(sx) + svl_pkg::DIST_W'(sy) + svl_pkg::DIST_W'(sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_dist  <= dsum;
    out_value <= seed.value;
    out_idx   <= in_idx;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/nearest_seed_voronoi_lookup_top.sv
`default_nettype none
// Clear and append leave the state idle; a new request is taken in the next cycle.
// A query over N >= 1 stored seeds scans them and loads the nearest as its result;
// an empty table loads an empty result; the next request is taken the cycle after.
// The scan reads one table entry per cycle from the single memory read port.
// A result waiting in the output register holds back only the next query's load.
// Reset zeroes the seed count; table contents stay undefined until written.
module nearest_seed_voronoi_lookup_top #(
  parameter int unsigned MAX_POINTS = svl_pkg::MAX_POINTS
) (
  input  wire logic clk,
  input  wire logic rst,
  svl_req_if.sink   req,
  svl_rsp_if.source rsp
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  svl_pkg::state_t state, state_next;

  logic [CW-1:0]                 count;
  logic [CW-1:0]                 issue_idx;
  logic                          s1_valid;
  logic [AW-1:0]                 s1_idx;
  logic [svl_pkg::COORD_W-1:0]   qx, qy, qz;

  logic                          have;
  logic [svl_pkg::DIST_W-1:0]    best_dist;
  logic [AW-1:0]                 best_idx;
  logic [svl_pkg::VALUE_W-1:0]   best_value;

  logic                          s2_valid;
  logic [svl_pkg::DIST_W-1:0]    s2_dist;
  logic [svl_pkg::VALUE_W-1:0]   s2_value;
  logic [AW-1:0]                 s2_idx;

  svl_pkg::seed_entry_t          wr_entry, rd_entry;

  logic accept, issue, load_res, append_ok, better, scan_done;

  // Handshake and control outputs
  always_comb begin
    req.ready = (state == svl_pkg::ST_IDLE);
    issue     = (state == svl_pkg::ST_SCAN) && (issue_idx < count);
    load_res  = (state == svl_pkg::ST_DONE) && (!rsp.valid || rsp.ready);
  end

  assign accept    = req.valid && req.ready;
  assign append_ok = accept && (req.command == svl_pkg::CMD_APPEND) &&
                     (count < CW'(MAX_POINTS));
  assign scan_done = (issue_idx == count) && !s1_valid && !s2_valid;
  assign better    = s2_valid && (!have || (s2_dist < best_dist));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      svl_pkg::ST_IDLE: begin
        if (accept && (req.command == svl_pkg::CMD_QUERY)) begin
          state_next = svl_pkg::ST_SCAN;
        end
      end
      svl_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = svl_pkg::ST_DONE;
        end
      end
      svl_pkg::ST_DONE: begin
        if (load_res) begin
          state_next = svl_pkg::ST_IDLE;
        end
      end
      default: state_next = svl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Seed count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && (req.command == svl_pkg::CMD_CLEAR)) begin
      count <= '0;
    end else if (append_ok) begin
      count <= count + 1'b1;
    end
  end

  // Table write and read
  assign wr_entry = '{x: req.coord_x, y: req.coord_y, z: req.coord_z,
                      value: req.seed_value};

  svl_seed_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (append_ok),
    .waddr (count[AW-1:0]),
    .wdata (wr_entry),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_entry)
  );

  // Scan issue counter and read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (accept && (req.command == svl_pkg::CMD_QUERY)) begin
        issue_idx <= '0;
      end else if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= issue_idx[AW-1:0];
    if (accept && (req.command == svl_pkg::CMD_QUERY)) begin
      qx <= svl_pkg::sat_coord(req.coord_x);
      qy <= svl_pkg::sat_coord(req.coord_y);
      qz <= svl_pkg::sat_coord(req.coord_z);
    end
  end

  svl_dist #(
    .AW (AW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .seed      (rd_entry),
    .in_idx    (s1_idx),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .out_valid (s2_valid),
    .out_dist  (s2_dist),
    .out_value (s2_value),
    .out_idx   (s2_idx)
  );

  // Running best; strictly smaller replaces, so the first seed keeps a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept && (req.command == svl_pkg::CMD_QUERY)) begin
      have <= 1'b0;
    end else if (better) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_dist  <= s2_dist;
      best_idx   <= s2_idx;
      best_value <= s2_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_res) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      rsp.nearest_value <= have ? best_value : '0;
      rsp.nearest_index <= have ? svl_pkg::IDX_W'(best_idx) : '0;
      rsp.table_empty   <= !have;
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("seed count above table depth");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    (s1_valid || s2_valid) |-> (state == svl_pkg::ST_SCAN))
    else $error("scan pipeline busy outside scan");

  a_have_nonempty: assert property (@(posedge clk) disable iff (rst)
    ((state == svl_pkg::ST_DONE) && have) |-> (count != '0))
    else $error("best seed found in empty table");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load_res |=> (rsp.valid && (state == svl_pkg::ST_IDLE)))
    else $error("result load did not complete query");

endmodule
`default_nettype wire
